@@ rtl/lphs_pkg.sv @@
// Shared types and constants for the linear-probe hash set.
// No dependencies; imported by every module of the block except lphs_ram.
`timescale 1ns / 1ps

package lphs_pkg;

    localparam int KEY_BITS = 48;
    localparam int PCT_W    = 7;
    localparam int MINLG_W  = 4;
    localparam int CNT_W    = 15;
    localparam int LGO_W    = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LG = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHRINK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRUNE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GROW   = 2'd3;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_REPLACED  = 3'd1;
    localparam logic [2:0] ST_REMOVED   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    localparam logic MODE_REGISTER   = 1'b0;
    localparam logic MODE_UNREGISTER = 1'b1;

    localparam logic [31:0] MIX_C1 = 32'h85EBCA6B;
    localparam logic [31:0] MIX_C2 = 32'hC2B2AE35;
    localparam logic [1:0]  MIX_LATENCY = 2'd3;

    typedef struct packed {
        logic                mode;
        logic [KEY_BITS-1:0] key;
    } cmd_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [CNT_W-1:0] live_count;
        logic [CNT_W-1:0] dead_count;
        logic [LGO_W-1:0] size_in_use_log2;
    } result_t;

    typedef struct packed {
        logic [MINLG_W-1:0] min_size_log2;
        logic [PCT_W-1:0]   shrink_pct;
        logic [PCT_W-1:0]   prune_pct;
        logic [PCT_W-1:0]   grow_pct;
    } cfg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK,
        S_DECIDE,
        S_CLEAR,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SCAN_NXT,
        S_REB_END,
        S_HASH,
        S_P_RD,
        S_P_CHK,
        S_DONE
    } ctrl_state_t;

endpackage

@@ rtl/lphs_mix.sv @@
// Pipelined key mixer, 48-bit key to 32-bit hash, three register stages.
// Depends on lphs_pkg.
`timescale 1ns / 1ps

module lphs_mix
    import lphs_pkg::*;
(
    input  logic                clk,
    input  logic [KEY_BITS-1:0] key,
    output logic [31:0]         hash
);

    logic [63:0] k64;
    logic [31:0] fold;
    logic [31:0] s1_reg;
    logic [31:0] m1_reg;
    logic [31:0] m1x;
    logic [31:0] m2_reg;

    assign k64  = 64'(key);
    assign fold = k64[31:0] ^ k64[63:32];
    assign m1x  = m1_reg ^ (m1_reg >> 13);

    always_ff @(posedge clk)
    begin
        s1_reg <= fold ^ (fold >> 16);
        m1_reg <= s1_reg * MIX_C1;
        m2_reg <= m1x * MIX_C2;
    end

    assign hash = m2_reg ^ (m2_reg >> 16);

endmodule

@@ rtl/lphs_ram.sv @@
// Slot store: simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module lphs_ram #(
    parameter int ADDR_W = 15,
    parameter int DATA_W = 50
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/lphs_ctrl.sv @@
// Sequencer: resize policy, bank clear/rebuild and linear probing over the RAM.
// Depends on lphs_pkg, lphs_mix and lphs_ram.
`timescale 1ns / 1ps

module lphs_ctrl
    import lphs_pkg::*;
#(
    parameter int MAX_SIZE_LOG2 = 14
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  cmd_t    cmd,
    input  cfg_t    cfg,
    output logic    busy,
    output logic    done,
    output result_t result
);

    localparam int IW  = MAX_SIZE_LOG2;
    localparam int AW  = MAX_SIZE_LOG2 + 1;
    localparam int CW  = MAX_SIZE_LOG2 + 1;
    localparam int LGW = $clog2(MAX_SIZE_LOG2 + 1);
    localparam int PW  = MAX_SIZE_LOG2 + 8;
    localparam int DW  = KEY_BITS + 2;

    function automatic logic [IW-1:0] lg_mask(input logic [LGW-1:0] l);
        lg_mask = IW'((32'd1 << l) - 32'd1);
    endfunction

    ctrl_state_t state_reg, state_next;

    logic                mode_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] pkey_reg;
    logic [LGW-1:0]      lg_reg;
    logic [LGW-1:0]      new_lg_reg;
    logic                bank_reg;
    logic [CW-1:0]       live_reg;
    logic [CW-1:0]       dead_reg;
    logic [IW-1:0]       idx_reg;
    logic [IW-1:0]       n_reg;
    logic [IW-1:0]       clr_reg;
    logic [IW-1:0]       scan_reg;
    logic [1:0]          wait_reg;
    logic [2:0]          status_reg;
    logic                rb_reg;
    logic                rm_reg;
    logic                shrink_reg;
    logic                over_reg;
    logic                prune_reg;

    logic [LGW-1:0] min_lg;
    logic [31:0]    hash;
    logic [LGW-1:0] p_lg;
    logic           p_bank;
    logic [IW-1:0]  p_mask;
    logic [IW-1:0]  old_mask;
    logic [IW-1:0]  new_mask;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [DW-1:0] ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [DW-1:0] ram_rdata;

    logic          e_live;
    logic          e_dead;
    logic          e_empty;
    logic          e_match;

    logic [PW-1:0] live_p1_x100;
    logic [PW-1:0] sum_x100;
    logic          shrink_f;
    logic          over_f;
    logic          prune_f;

    lphs_mix u_mix (
        .clk  (clk),
        .key  (pkey_reg),
        .hash (hash)
    );

    lphs_ram #(
        .ADDR_W (AW),
        .DATA_W (DW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // min size clamped to 1 .. MAX_SIZE_LOG2
    always_comb
    begin
        if (cfg.min_size_log2 == '0)
        begin
            min_lg = LGW'(1);
        end
        else if (8'(cfg.min_size_log2) > 8'(MAX_SIZE_LOG2))
        begin
            min_lg = LGW'(MAX_SIZE_LOG2);
        end
        else
        begin
            min_lg = LGW'(cfg.min_size_log2);
        end
    end

    assign p_lg     = rb_reg ? new_lg_reg : lg_reg;
    assign p_bank   = rb_reg ? ~bank_reg : bank_reg;
    assign p_mask   = lg_mask(p_lg);
    assign old_mask = lg_mask(lg_reg);
    assign new_mask = lg_mask(new_lg_reg);

    assign e_live  = ram_rdata[KEY_BITS];
    assign e_dead  = ram_rdata[KEY_BITS+1];
    assign e_empty = !e_live && !e_dead;
    assign e_match = e_live && (ram_rdata[KEY_BITS-1:0] == pkey_reg);

    // count < floor(size*pct/100)  <=>  100*(count+1) <= size*pct
    // count > floor(size*pct/100)  <=>  100*count > size*pct
    assign live_p1_x100 = (PW'(live_reg) + PW'(1)) * PW'(100);
    assign sum_x100     = (PW'(live_reg) + PW'(dead_reg)) * PW'(100);

    always_comb
    begin
        shrink_f = (live_p1_x100 <= (PW'(cfg.shrink_pct) << lg_reg)) && (lg_reg > min_lg)
                   && (live_reg <= (CW'(1) << (lg_reg - LGW'(1))));
        over_f   = sum_x100 > (PW'(cfg.grow_pct) << lg_reg);
        prune_f  = (live_p1_x100 <= (PW'(cfg.prune_pct) << lg_reg))
                   || (lg_reg >= LGW'(MAX_SIZE_LOG2));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (cmd.mode == MODE_UNREGISTER)
                    begin
                        state_next = (lg_reg == '0) ? S_DONE : S_HASH;
                    end
                    else
                    begin
                        state_next = (lg_reg == '0) ? S_CLEAR : S_CHK;
                    end
                end
            end
            S_CHK:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = (shrink_reg || over_reg) ? S_CLEAR : S_HASH;
            end
            S_CLEAR:
            begin
                if (clr_reg == new_mask)
                begin
                    state_next = (lg_reg == '0) ? S_REB_END : S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                state_next = e_live ? S_HASH : S_SCAN_NXT;
            end
            S_SCAN_NXT:
            begin
                state_next = (scan_reg == old_mask) ? S_REB_END : S_SCAN_RD;
            end
            S_REB_END:
            begin
                state_next = S_HASH;
            end
            S_HASH:
            begin
                if (wait_reg == MIX_LATENCY)
                begin
                    state_next = S_P_RD;
                end
            end
            S_P_RD:
            begin
                state_next = S_P_CHK;
            end
            S_P_CHK:
            begin
                if (e_empty || e_match || (n_reg == p_mask))
                begin
                    state_next = rb_reg ? S_SCAN_NXT : S_DONE;
                end
                else
                begin
                    state_next = S_P_RD;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // RAM and handshake outputs
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = {p_bank, idx_reg};
        ram_wdata = {2'b01, pkey_reg};
        ram_re    = 1'b0;
        ram_raddr = {p_bank, idx_reg};
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = {~bank_reg, clr_reg};
                ram_wdata = '0;
            end
            S_SCAN_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = {bank_reg, scan_reg};
            end
            S_P_RD:
            begin
                ram_re = 1'b1;
            end
            S_P_CHK:
            begin
                if (rm_reg)
                begin
                    ram_we    = e_match;
                    ram_wdata = {2'b10, {KEY_BITS{1'b0}}};
                end
                else
                begin
                    ram_we = e_empty || e_match;
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

    assign result.status           = status_reg;
    assign result.live_count       = CNT_W'(live_reg);
    assign result.dead_count       = CNT_W'(dead_reg);
    assign result.size_in_use_log2 = LGO_W'(lg_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            lg_reg    <= '0;
            bank_reg  <= 1'b0;
            live_reg  <= '0;
            dead_reg  <= '0;
            wait_reg  <= '0;
            rb_reg    <= 1'b0;
            rm_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        mode_reg   <= cmd.mode;
                        key_reg    <= cmd.key;
                        pkey_reg   <= cmd.key;
                        rb_reg     <= 1'b0;
                        rm_reg     <= (cmd.mode == MODE_UNREGISTER);
                        wait_reg   <= '0;
                        clr_reg    <= '0;
                        new_lg_reg <= min_lg;
                        status_reg <= ST_NOT_FOUND;
                    end
                end
                S_CHK:
                begin
                    shrink_reg <= shrink_f;
                    over_reg   <= over_f;
                    prune_reg  <= prune_f;
                end
                S_DECIDE:
                begin
                    if (shrink_reg)
                    begin
                        new_lg_reg <= lg_reg - LGW'(1);
                    end
                    else if (prune_reg)
                    begin
                        new_lg_reg <= lg_reg;
                    end
                    else
                    begin
                        new_lg_reg <= lg_reg + LGW'(1);
                    end
                end
                S_CLEAR:
                begin
                    clr_reg  <= clr_reg + IW'(1);
                    scan_reg <= '0;
                end
                S_SCAN_CHK:
                begin
                    if (e_live)
                    begin
                        pkey_reg <= ram_rdata[KEY_BITS-1:0];
                        rb_reg   <= 1'b1;
                        wait_reg <= '0;
                    end
                end
                S_SCAN_NXT:
                begin
                    scan_reg <= scan_reg + IW'(1);
                end
                S_REB_END:
                begin
                    bank_reg <= ~bank_reg;
                    lg_reg   <= new_lg_reg;
                    dead_reg <= '0;
                    pkey_reg <= key_reg;
                    rb_reg   <= 1'b0;
                    wait_reg <= '0;
                end
                S_HASH:
                begin
                    wait_reg <= wait_reg + 2'd1;
                    idx_reg  <= hash[IW-1:0] & p_mask;
                    n_reg    <= '0;
                end
                S_P_CHK:
                begin
                    if (e_empty)
                    begin
                        if (rm_reg)
                        begin
                            status_reg <= ST_NOT_FOUND;
                        end
                        else if (!rb_reg)
                        begin
                            status_reg <= ST_INSERTED;
                            live_reg   <= live_reg + CW'(1);
                        end
                    end
                    else if (e_match)
                    begin
                        if (rm_reg)
                        begin
                            status_reg <= ST_REMOVED;
                            live_reg   <= live_reg - CW'(1);
                            dead_reg   <= dead_reg + CW'(1);
                        end
                        else
                        begin
                            status_reg <= ST_REPLACED;
                        end
                    end
                    else if (n_reg == p_mask)
                    begin
                        status_reg <= (mode_reg == MODE_UNREGISTER) ? ST_NOT_FOUND : ST_FULL;
                    end
                    else
                    begin
                        n_reg   <= n_reg + IW'(1);
                        idx_reg <= (idx_reg + IW'(1)) & p_mask;
                    end
                end
                default:
                begin
                    wait_reg <= wait_reg;
                end
            endcase
        end
    end

endmodule

@@ rtl/linear_probe_hash_set_with_resize_unit.sv @@
// Top level of the linear-probe hash set: configuration registers and sequencer.
// Depends on lphs_pkg and lphs_ctrl.
//
//   channel   signals                                   transfer when
//   command   start, busy, cmd                          start && !busy
//   result    done, result                              done (one cycle, no stall)
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid && cfg_ready
//
// One item at a time; the result is shown in the last busy cycle. A register
// item on a built table first passes the resize check (S_CHK, S_DECIDE); an
// item then hashes through the 3-stage mixer and probes with a RAM read and a
// check per slot. An unregister on an unbuilt table goes straight to done.
// A register item that triggers a rebuild first clears the 2^new_lg slots of
// the new bank, then reads every old slot and runs a probe sequence per live key.
// Reset leaves the table unbuilt; a bank is always cleared before it is used.
// Config writes are taken every cycle; the result side cannot stall.
`timescale 1ns / 1ps

module linear_probe_hash_set_with_resize_unit
    import lphs_pkg::*;
#(
    parameter int MAX_SIZE_LOG2 = 14
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  cmd_t                 cmd,
    output logic                 done,
    output result_t              result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PCT_W-1:0]     cfg_data
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_size_log2 <= MINLG_W'(10);
            cfg_reg.shrink_pct    <= PCT_W'(30);
            cfg_reg.prune_pct     <= PCT_W'(65);
            cfg_reg.grow_pct      <= PCT_W'(70);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MIN_LG: cfg_reg.min_size_log2 <= cfg_data[MINLG_W-1:0];
                CFG_SHRINK: cfg_reg.shrink_pct    <= cfg_data;
                CFG_PRUNE:  cfg_reg.prune_pct     <= cfg_data;
                CFG_GROW:   cfg_reg.grow_pct      <= cfg_data;
                default:    cfg_reg.grow_pct      <= cfg_reg.grow_pct;
            endcase
        end
    end

    lphs_ctrl #(
        .MAX_SIZE_LOG2 (MAX_SIZE_LOG2)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .cfg    (cfg_reg),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

endmodule

@@ verif/tb_linear_probe_hash_set_with_resize_unit.sv @@
// Self-checking bench for the linear-probe hash set: directed and random register
// and unregister commands under several resize settings, checked against a predictor.
// Depends on lphs_pkg and linear_probe_hash_set_with_resize_unit.
`timescale 1ns / 1ps

module tb_linear_probe_hash_set_with_resize_unit;
    import lphs_pkg::*;

    localparam int MAX_LG = 14;
    localparam int SLOTS  = 1 << MAX_LG;

    class hash_set_scoreboard;
        logic [KEY_BITS-1:0] slot_key [2][SLOTS];
        bit                  slot_live[2][SLOTS];
        bit                  slot_dead[2][SLOTS];
        int                  bank;
        int                  lg;
        int                  live;
        int                  dead;
        int                  min_lg_reg;
        int                  shrink_reg;
        int                  prune_reg;
        int                  grow_reg;
        result_t             expected_q[$];
        int                  errors;
        int                  mismatches;

        function void clear_state();
            for (int b = 0; b < 2; b++)
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    slot_key[b][i]  = '0;
                    slot_live[b][i] = 0;
                    slot_dead[b][i] = 0;
                end
            end
            bank = 0; lg = 0; live = 0; dead = 0;
            min_lg_reg = 10; shrink_reg = 30; prune_reg = 65; grow_reg = 70;
            errors = 0; mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [PCT_W-1:0] data);
            case (idx)
                CFG_MIN_LG: min_lg_reg = data[3:0];
                CFG_SHRINK: shrink_reg = data;
                CFG_PRUNE:  prune_reg  = data;
                CFG_GROW:   grow_reg   = data;
                default: ;
            endcase
        endfunction

        function logic [31:0] slot_hash(logic [KEY_BITS-1:0] k);
            logic [63:0] wide;
            logic [31:0] h;
            wide = 64'(k);
            h = wide[31:0] ^ wide[63:32];
            h = h ^ (h >> 16);
            h = h * MIX_C1;
            h = h ^ (h >> 13);
            h = h * MIX_C2;
            h = h ^ (h >> 16);
            return h;
        endfunction

        function logic [2:0] place_key(int b, int l, logic [KEY_BITS-1:0] k);
            int mask;
            int idx;
            mask = (1 << l) - 1;
            idx = slot_hash(k) & mask;
            for (int n = 0; n <= mask; n++)
            begin
                if (!slot_live[b][idx] && !slot_dead[b][idx])
                begin
                    slot_live[b][idx] = 1;
                    slot_key[b][idx] = k;
                    return ST_INSERTED;
                end
                if (slot_live[b][idx] && slot_key[b][idx] == k)
                    return ST_REPLACED;
                idx = (idx + 1) & mask;
            end
            return ST_FULL;
        endfunction

        function void rebuild_table(int new_lg);
            int nb;
            int old_n;
            nb = bank ^ 1;
            old_n = (lg != 0) ? (1 << lg) : 0;
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_live[nb][i] = 0;
                slot_dead[nb][i] = 0;
                slot_key[nb][i]  = '0;
            end
            for (int i = 0; i < old_n; i++)
                if (slot_live[bank][i])
                    void'(place_key(nb, new_lg, slot_key[bank][i]));
            bank = nb;
            lg = new_lg;
            dead = 0;
        endfunction

        function void apply_policy();
            int min_lg;
            longint unsigned sz, shrink_t, prune_t, grow_t;
            min_lg = min_lg_reg;
            if (min_lg < 1) min_lg = 1;
            if (min_lg > MAX_LG) min_lg = MAX_LG;
            if (lg == 0)
            begin
                rebuild_table(min_lg);
                return;
            end
            sz = longint'(1) << lg;
            shrink_t = sz * shrink_reg / 100;
            prune_t  = sz * prune_reg / 100;
            grow_t   = sz * grow_reg / 100;
            if (live < shrink_t && lg > min_lg && live <= sz / 2)
                rebuild_table(lg - 1);
            else if (live + dead > grow_t)
            begin
                if (live < prune_t || lg >= MAX_LG)
                    rebuild_table(lg);
                else
                    rebuild_table(lg + 1);
            end
        endfunction

        function logic [2:0] drop_key(logic [KEY_BITS-1:0] k);
            int mask;
            int idx;
            if (lg == 0)
                return ST_NOT_FOUND;
            mask = (1 << lg) - 1;
            idx = slot_hash(k) & mask;
            for (int n = 0; n <= mask; n++)
            begin
                if (!slot_live[bank][idx] && !slot_dead[bank][idx])
                    return ST_NOT_FOUND;
                if (slot_live[bank][idx] && slot_key[bank][idx] == k)
                begin
                    slot_live[bank][idx] = 0;
                    slot_dead[bank][idx] = 1;
                    slot_key[bank][idx] = '0;
                    live--;
                    dead++;
                    return ST_REMOVED;
                end
                idx = (idx + 1) & mask;
            end
            return ST_NOT_FOUND;
        endfunction

        function void note_command(cmd_t c);
            result_t r;
            if (c.mode == MODE_REGISTER)
            begin
                apply_policy();
                r.status = place_key(bank, lg, c.key);
                if (r.status == ST_INSERTED)
                    live++;
            end
            else
                r.status = drop_key(c.key);
            r.live_count = live[CNT_W-1:0];
            r.dead_count = dead[CNT_W-1:0];
            r.size_in_use_log2 = lg[LGO_W-1:0];
            expected_q.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("unexpected result %p", got);
                return;
            end
            want = expected_q.pop_front();
            if (got !== want)
            begin
                errors++;
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic                 clk = 0;
    logic                 rst_n = 0;
    logic                 start = 0;
    logic                 busy;
    cmd_t                 cmd = '0;
    logic                 done;
    result_t              result;
    logic                 cfg_valid = 0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [PCT_W-1:0]     cfg_data = '0;

    hash_set_scoreboard sb;
    logic [KEY_BITS-1:0] key_pool[$];

    linear_probe_hash_set_with_resize_unit #(.MAX_SIZE_LOG2(MAX_LG)) u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    always @(posedge clk)
        if (rst_n && done)
            sb.check_result(result);

    // start stays high across back-to-back transfers when the gap is zero
    task automatic send_cmd(logic m, logic [KEY_BITS-1:0] k);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            start <= 0;
            repeat (gap) @(posedge clk);
        end
        start <= 1;
        cmd <= '{mode: m, key: k};
        do
            @(posedge clk);
        while (busy);
        sb.note_command('{mode: m, key: k});
    endtask

    task automatic drain();
        start <= 0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [PCT_W-1:0] data);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, data);
        cfg_valid <= 0;
    endtask

    task automatic set_policy(int min_lg, int shr, int prn, int grw);
        write_cfg(CFG_MIN_LG, PCT_W'(min_lg));
        write_cfg(CFG_SHRINK, PCT_W'(shr));
        write_cfg(CFG_PRUNE, PCT_W'(prn));
        write_cfg(CFG_GROW, PCT_W'(grw));
        @(posedge clk);
    endtask

    function automatic logic [KEY_BITS-1:0] rand_key();
        return KEY_BITS'({$urandom, $urandom});
    endfunction

    task automatic random_phase(int n_items);
        int pool_n;
        logic [KEY_BITS-1:0] k;
        pool_n = $urandom_range(4, 40);
        key_pool.delete();
        for (int i = 0; i < pool_n; i++)
            key_pool.push_back(($urandom_range(0, 4) == 0) ?
                               KEY_BITS'($urandom_range(0, 255)) : rand_key());
        for (int i = 0; i < n_items; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                k = rand_key();
            else
                k = key_pool[$urandom_range(0, pool_n - 1)];
            send_cmd(($urandom_range(0, 9) < 6) ? MODE_REGISTER : MODE_UNREGISTER, k);
            if ($urandom_range(0, 59) == 0)
                drain();
        end
        drain();
    endtask

    initial
    begin
        #40_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        sb = new();
        sb.clear_state();
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // defaults: unbuilt table, key zero, largest key, replace, remove twice
        send_cmd(MODE_UNREGISTER, 48'h1234);
        send_cmd(MODE_REGISTER, '0);
        send_cmd(MODE_REGISTER, '1);
        send_cmd(MODE_REGISTER, '0);
        send_cmd(MODE_UNREGISTER, '1);
        send_cmd(MODE_UNREGISTER, '1);
        drain();

        // min clamps to 1, shrink above 100 halves on every register down to size 2
        set_policy(0, 127, 100, 100);
        for (int i = 0; i < 10; i++)
            send_cmd(MODE_REGISTER, (i % 2) ? 48'h5555_5555_5555 : '0);
        drain();

        // size 2 with no growth room: third key finds the table full
        set_policy(1, 0, 100, 100);
        send_cmd(MODE_REGISTER, 48'hAAAA_AAAA_AAAA);
        send_cmd(MODE_REGISTER, 48'h0000_0000_0077);
        send_cmd(MODE_UNREGISTER, 48'h0000_0000_0099);
        drain();

        // min out of range clamps to max; zero grow threshold doubles up to max, then prunes
        set_policy(15, 0, 0, 0);
        for (int i = 0; i < 14; i++)
            send_cmd(MODE_REGISTER, rand_key());
        drain();

        set_policy(14, 50, 50, 50);
        send_cmd(MODE_REGISTER, rand_key());
        drain();

        // sparse table shrinks back down
        set_policy(2, 127, 65, 100);
        random_phase(40);

        for (int p = 0; p < 6; p++)
        begin
            set_policy($urandom_range(0, 6),
                       ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 50),
                       $urandom_range(0, 127),
                       ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(40, 100));
            random_phase(235);
        end

        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/lphs_pkg.sv
rtl/lphs_mix.sv
rtl/lphs_ram.sv
rtl/lphs_ctrl.sv
rtl/linear_probe_hash_set_with_resize_unit.sv
verif/tb_linear_probe_hash_set_with_resize_unit.sv
